/* hw/rtl/osrm_pkg.sv */
// Package for the ordered store with remove-max.
// Sizes, command and status codes, and controller/datapath command types.
// No dependencies.
package osrm_pkg;

  localparam int DEPTH  = 64;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int ECNT_W = 7;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int CMPW   = (CW > POS_W) ? CW : POS_W;
  localparam int IN_DW  = 40;
  localparam int IN_UW  = 2;
  localparam int OUT_DW = 48;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [AW-1:0]           addr_t;
  typedef logic [CW-1:0]           count_t;
  typedef logic [POS_W-1:0]        pos_t;

  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_REMOVE_MAX,
    CMD_READ,
    CMD_CLEAR
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_RANGE
  } status_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef enum logic [1:0] {
    RES_VAL,
    RES_RDATA,
    RES_BEST,
    RES_ZERO
  } res_src_t;

  typedef struct packed {
    logic     capture;
    logic     wr_app;
    logic     rd_en;
    logic     rd_pos;
    logic     idx_inc;
    logic     idx_best1;
    logic     cmp_en;
    logic     sh_en;
    cnt_op_t  cnt_op;
    logic     res_load;
    res_src_t res_src;
    status_t  res_st;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic cnt_zero;
    logic cnt_full;
    logic pos_ok;
    logic idx_at_cnt;
    logic pend;
  } dp_sts_t;

endpackage

/* hw/rtl/ordered_store_remove_max_core.sv */
// Ordered store with append, remove-max, read and clear commands.
// Channels: in_* carries one command transaction, out_* one result per command.
// Steps per command, with N entries held:
//   append, clear, or any rejected command: decode, then finish
//   read: decode, a wait for the registered RAM read, then finish
//   remove-max: a scan pass over N entries through the single read port of
//   the entry RAM, then a shift pass over the entries after the maximum,
//   which is empty when the maximum is the last entry
// One command is worked at a time; the next one is accepted the cycle after
// a result is loaded.
// in_tready is high while no command is in progress, also while a finished
// result still waits in the output register.
// When the receiver stalls, the next command runs but its result waits until
// the previous one is taken.
// Reset (rst_n low, synchronous) empties the store and drops any pending
// result; entry contents are not cleared and are read only once written.
// Depends on osrm_pkg, osrm_ctrl, osrm_dp, osrm_ram.
module ordered_store_remove_max_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [31:0] value, [37:32] position, [39:38] zero
  input  logic [osrm_pkg::IN_DW-1:0]   in_tdata,
  // [1:0] command
  input  logic [osrm_pkg::IN_UW-1:0]   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [31:0] result_value, [38:32] entry_count, [40:39] status, [47:41] zero
  output logic [osrm_pkg::OUT_DW-1:0]  out_tdata
);
  import osrm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  osrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  osrm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .out_tdata(out_tdata)
  );

endmodule

/* hw/rtl/osrm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module osrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/osrm_ctrl.sv */
// Controller state machine for the ordered store.
// Sequences append, read, clear and the scan/shift passes of remove-max.
// Depends on osrm_pkg.
module osrm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output osrm_pkg::dp_cmd_t cmd,
  input  osrm_pkg::dp_sts_t sts
);
  import osrm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_SCAN,
    S_SHIFT_START,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.cnt_op  = CNT_HOLD;
    cmd.res_src = RES_ZERO;
    cmd.res_st  = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.cmd)
          CMD_APPEND: begin
            cmd.res_load = 1'b1;
            cmd.res_src  = RES_VAL;
            if (sts.cnt_full) begin
              cmd.res_st = ST_FULL;
            end else begin
              cmd.wr_app = 1'b1;
              cmd.cnt_op = CNT_INC;
            end
            state_nxt = S_FINISH;
          end
          CMD_REMOVE_MAX: begin
            if (sts.cnt_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_st   = ST_EMPTY;
              state_nxt    = S_FINISH;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.idx_inc = 1'b1;
              state_nxt   = S_SCAN;
            end
          end
          CMD_READ: begin
            if (sts.pos_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_pos = 1'b1;
              state_nxt  = S_RD_WAIT;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_st   = ST_RANGE;
              state_nxt    = S_FINISH;
            end
          end
          default: begin
            cmd.cnt_op   = CNT_CLR;
            cmd.res_load = 1'b1;
            state_nxt    = S_FINISH;
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.res_load = 1'b1;
        cmd.res_src  = RES_RDATA;
        state_nxt    = S_FINISH;
      end
      S_SCAN: begin
        cmd.cmp_en = 1'b1;
        if (sts.idx_at_cnt) begin
          state_nxt = S_SHIFT_START;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHIFT_START: begin
        cmd.idx_best1 = 1'b1;
        state_nxt     = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.sh_en = 1'b1;
        if (!sts.idx_at_cnt) begin
          cmd.rd_en   = 1'b1;
          cmd.idx_inc = 1'b1;
        end else if (!sts.pend) begin
          cmd.cnt_op   = CNT_DEC;
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_BEST;
          state_nxt    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid_r || out_tready))
    else $error("result loaded over an untaken result");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DECODE))
    else $error("accepted transaction not decoded");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> out_tvalid_r)
    else $error("result dropped while stalled");
`endif

endmodule

/* hw/rtl/osrm_dp.sv */
// Datapath for the ordered store: entry RAM, count, scan and shift indexes,
// running maximum and result registers. Depends on osrm_pkg and osrm_ram.
module osrm_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [osrm_pkg::IN_DW-1:0]   in_tdata,
  input  logic [osrm_pkg::IN_UW-1:0]   in_tuser,
  input  osrm_pkg::dp_cmd_t            cmd,
  output osrm_pkg::dp_sts_t            sts,
  output logic [osrm_pkg::OUT_DW-1:0]  out_tdata
);
  import osrm_pkg::*;

  cmd_t    op_r;
  value_t  val_r;
  pos_t    pos_r;
  count_t  count_r, count_nxt;
  count_t  idx_r, idx_nxt;
  addr_t   best_idx_r;
  value_t  best_val_r;
  logic    pend_r;
  addr_t   pend_addr_r;
  value_t  res_val_r;
  status_t res_st_r;
  value_t  out_val_r;
  count_t  out_cnt_r;
  status_t out_st_r;

  logic       ram_we;
  addr_t      ram_waddr;
  value_t     ram_wdata;
  addr_t      ram_raddr;
  logic [VAL_W-1:0] ram_rdata;
  value_t     rdata;
  logic       first;

  assign rdata = value_t'(ram_rdata);

  osrm_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd_en),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_raddr = cmd.rd_pos ? addr_t'(pos_r) : idx_r[AW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = val_r;
    if (cmd.wr_app) begin
      ram_we = 1'b1;
    end else if (cmd.sh_en && pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r - addr_t'(1);
      ram_wdata = rdata;
    end
  end

  assign sts.cmd        = op_r;
  assign sts.cnt_zero   = (count_r == '0);
  assign sts.cnt_full   = (count_r >= count_t'(DEPTH));
  assign sts.pos_ok     = (CMPW'(pos_r) < CMPW'(count_r));
  assign sts.idx_at_cnt = (idx_r == count_r);
  assign sts.pend       = pend_r;

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: count_nxt = count_r + count_t'(1);
      CNT_DEC: count_nxt = count_r - count_t'(1);
      CNT_CLR: count_nxt = '0;
      default: count_nxt = count_r;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.capture) begin
      idx_nxt = '0;
    end else if (cmd.idx_best1) begin
      idx_nxt = count_t'(best_idx_r) + count_t'(1);
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + count_t'(1);
    end
  end

  // rdata holds entry idx_r-1 during the scan
  assign first = (idx_r == count_t'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= cmd.sh_en && cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.rd_en) begin
      pend_addr_r <= ram_raddr;
    end
    if (cmd.capture) begin
      op_r  <= cmd_t'(in_tuser);
      val_r <= value_t'(in_tdata[VAL_W-1:0]);
      pos_r <= in_tdata[VAL_W+POS_W-1:VAL_W];
    end
    if (cmd.cmp_en && (first || (rdata > best_val_r))) begin
      best_val_r <= rdata;
      best_idx_r <= addr_t'(idx_r - count_t'(1));
    end
    if (cmd.res_load) begin
      res_st_r <= cmd.res_st;
      case (cmd.res_src)
        RES_VAL:   res_val_r <= val_r;
        RES_RDATA: res_val_r <= rdata;
        RES_BEST:  res_val_r <= best_val_r;
        default:   res_val_r <= '0;
      endcase
    end
    if (cmd.out_load) begin
      out_val_r <= res_val_r;
      out_cnt_r <= count_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_tdata = {7'b0, out_st_r, ECNT_W'(out_cnt_r), out_val_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= count_t'(DEPTH))
    else $error("entry count beyond depth");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_app |-> !sts.cnt_full)
    else $error("append written into a full store");

  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op == CNT_INC) |=> (count_r == $past(count_r) + count_t'(1)))
    else $error("count not advanced after append");
`endif

endmodule
